FILE: design/assert_macros.svh
// Assertion helpers shared by the design files; each expects clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define RRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition in one cycle brings a consequence in the next.
`define RRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/rrt_pkg.sv
package rrt_pkg;

  typedef enum logic [1:0] {
    OP_ISSUE = 2'd0,
    OP_REPLY = 2'd1,
    OP_SWEEP = 2'd2,
    OP_QUERY = 2'd3
  } op_e;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_BUSY = 1'b1;

  localparam logic [31:0] EXPIRY_RESET = 32'd1000000;

  typedef struct packed {
    op_e         op;
    logic [31:0] reply_id;
    logic [31:0] now_time;
  } in_word_t;

  typedef struct packed {
    logic [31:0] new_id;
    logic [31:0] round_trip;
    logic        found;
    logic [4:0]  expired_count;
    logic [4:0]  pending_count;
    logic        status;
  } out_word_t;

  // One table entry as held in the slot memory.
  typedef struct packed {
    logic        valid;
    logic [31:0] ident;
    logic [31:0] stamp;
  } slot_t;

endpackage

FILE: design/rrt_chan_if.sv
interface rrt_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: design/rrt_ram.sv
module rrt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

FILE: design/round_trip_request_tracker.sv
// Channel   Dir  Word                                        Accepted when
// in_i      in   op, reply_id, now_time                      in_i.valid & in_i.ready
// out_o     out  new_id, round_trip, found, expired_count,   out_o.valid & out_o.ready
//                pending_count, status
// cfg_i     in   expiry_limit                                cfg_i.valid (ready always high)
//
// The slot memory (one read port, one write port, registered read) sets the pace of
// each word: every entry visit costs a read, and a reply first turns its identifier
// into a slot index by a reciprocal multiply on accept and a multiply-subtract in the
// next cycle.
// After reset a clearing pass writes every slot empty with in_i.ready low;
// configuration writes are taken throughout.
// A finished result waits in the output register while the next word is accepted; that
// word stalls in its last step only if the output register is still full.

`include "assert_macros.svh"

module round_trip_request_tracker #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rrt_chan_if.sink   in_i,
  rrt_chan_if.source out_o,
  rrt_chan_if.sink   cfg_i
);
  import rrt_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(TABLE_DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
  localparam int unsigned SW = $bits(slot_t);

  // Reciprocal of the table depth, rounded up, scaled by 2^(32 + AW). The product with
  // any 32-bit identifier, shifted down, gives the exact quotient.
  localparam int unsigned SH = 32 + AW;
  localparam logic [32:0] RECIP =
    33'(((64'd1 << SH) + 64'(TABLE_DEPTH) - 64'd1) / 64'(TABLE_DEPTH));
  localparam logic [31:0] DEPTH_32 = 32'(TABLE_DEPTH);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_REM    = 3'd2;
  localparam logic [2:0] S_LOOK   = 3'd3;
  localparam logic [2:0] S_EVAL   = 3'd4;
  localparam logic [2:0] S_SWEEP  = 3'd5;
  localparam logic [2:0] S_SWTAIL = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  // Control state
  logic [2:0]    state_q, state_d;
  logic [AW-1:0] idx_q, idx_d;
  logic          chk_q, chk_d;
  logic [31:0]   next_id_q, next_id_d;
  logic [AW-1:0] next_slot_q, next_slot_d;
  logic [CW-1:0] pend_q, pend_d;
  logic [31:0]   limit_q, limit_d;
  logic          out_valid_q, out_valid_d;

  // Payload state
  op_e           op_q, op_d;
  logic [31:0]   rid_q, rid_d;
  logic [31:0]   quo_q, quo_d;
  logic [31:0]   now_q, now_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [AW-1:0] chk_addr_q, chk_addr_d;
  logic [CW-1:0] exp_q, exp_d;
  logic [31:0]   res_id_q, res_id_d;
  logic [31:0]   res_rtt_q, res_rtt_d;
  logic          res_found_q, res_found_d;
  logic          res_status_q, res_status_d;
  out_word_t     out_q, out_d;

  // Slot memory access
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  slot_t         ram_wslot;
  logic [SW-1:0] ram_rdata;
  slot_t         rd_slot;

  logic          out_free;
  logic [31:0]   age;
  logic          expire;
  logic [64:0]   rid_prod;
  logic          issue_busy;
  logic          done_fire;

  rrt_ram #(
    .Width(SW),
    .Depth(TABLE_DEPTH)
  ) u_slots (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wslot),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd_slot  = slot_t'(ram_rdata);
  assign out_free = !out_valid_q || out_o.ready;

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // Wrapping age of the entry just read; a sweep frees it once age passes the limit.
  assign age    = now_q - rd_slot.stamp;
  assign expire = chk_q && rd_slot.valid && (age > limit_q);

  // Scaled reciprocal product of the arriving reply identifier; its top bits are the
  // quotient by the table depth.
  assign rid_prod = 65'(in_i.data.reply_id) * 65'(RECIP);

  assign issue_busy = (state_q == S_EVAL) && (op_q == OP_ISSUE) && rd_slot.valid;
  assign done_fire  = (state_q == S_DONE) && out_free;

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    chk_d        = chk_q;
    next_id_d    = next_id_q;
    next_slot_d  = next_slot_q;
    pend_d       = pend_q;
    limit_d      = limit_q;
    out_valid_d  = out_valid_q;
    op_d         = op_q;
    rid_d        = rid_q;
    quo_d        = quo_q;
    now_d        = now_q;
    addr_d       = addr_q;
    chk_addr_d   = chk_addr_q;
    exp_d        = exp_q;
    res_id_d     = res_id_q;
    res_rtt_d    = res_rtt_q;
    res_found_d  = res_found_q;
    res_status_d = res_status_q;
    out_d        = out_q;

    ram_we    = 1'b0;
    ram_waddr = addr_q;
    ram_wslot = '0;
    ram_raddr = (state_q == S_SWEEP) ? idx_q : addr_q;

    if (cfg_i.valid) begin
      limit_d = cfg_i.data;
    end

    // Drop the result once the sink takes it.
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        // Empty one slot per cycle after reset.
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wslot = '0;
        if (idx_q == LAST) begin
          idx_d   = '0;
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_i.valid) begin
          op_d         = in_i.data.op;
          rid_d        = in_i.data.reply_id;
          now_d        = in_i.data.now_time;
          res_id_d     = '0;
          res_rtt_d    = '0;
          res_found_d  = 1'b0;
          res_status_d = STATUS_OK;
          exp_d        = '0;
          case (in_i.data.op)
            OP_ISSUE: begin
              addr_d  = next_slot_q;
              state_d = S_LOOK;
            end
            OP_REPLY: begin
              quo_d   = 32'(rid_prod >> SH);
              state_d = S_REM;
            end
            OP_SWEEP: begin
              idx_d   = '0;
              chk_d   = 1'b0;
              state_d = S_SWEEP;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_REM: begin
        // Take the quotient times the depth off the identifier to leave the slot.
        addr_d  = AW'(rid_q - quo_q * DEPTH_32);
        state_d = S_LOOK;
      end
      S_LOOK: begin
        state_d = S_EVAL;
      end
      S_EVAL: begin
        if (op_q == OP_ISSUE) begin
          if (rd_slot.valid) begin
            res_status_d = STATUS_BUSY;
          end else begin
            ram_we          = 1'b1;
            ram_wslot.valid = 1'b1;
            ram_wslot.ident = next_id_q;
            ram_wslot.stamp = now_q;
            res_id_d        = next_id_q;
            next_id_d       = next_id_q + 32'd1;
            pend_d          = pend_q + 1'b1;
            // The slot restarts at zero after the last slot, and also when the identifier wraps.
            if (next_id_q == '1 || next_slot_q == LAST) begin
              next_slot_d = '0;
            end else begin
              next_slot_d = next_slot_q + 1'b1;
            end
          end
        end else if (rd_slot.valid && rd_slot.ident == rid_q) begin
          ram_we          = 1'b1;
          ram_wslot       = rd_slot;
          ram_wslot.valid = 1'b0;
          res_rtt_d       = now_q - rd_slot.stamp;
          res_found_d     = 1'b1;
          pend_d          = pend_q - 1'b1;
        end
        state_d = S_DONE;
      end
      S_SWEEP: begin
        // Read the next slot while the previous one is checked and written back.
        chk_d      = 1'b1;
        chk_addr_d = idx_q;
        if (idx_q == LAST) begin
          state_d = S_SWTAIL;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_SWTAIL: begin
        chk_d   = 1'b0;
        state_d = S_DONE;
      end
      S_DONE: begin
        // Hold here until the output register is free.
        if (out_free) begin
          out_d.new_id        = res_id_q;
          out_d.round_trip    = res_rtt_q;
          out_d.found         = res_found_q;
          out_d.expired_count = 5'(exp_q);
          out_d.pending_count = 5'(pend_q);
          out_d.status        = res_status_q;
          out_valid_d         = 1'b1;
          state_d             = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Free an expired entry found by the sweep.
    if ((state_q == S_SWEEP || state_q == S_SWTAIL) && expire) begin
      ram_we          = 1'b1;
      ram_waddr       = chk_addr_q;
      ram_wslot       = rd_slot;
      ram_wslot.valid = 1'b0;
      pend_d          = pend_q - 1'b1;
      exp_d           = exp_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      idx_q       <= '0;
      chk_q       <= 1'b0;
      next_id_q   <= '0;
      next_slot_q <= '0;
      pend_q      <= '0;
      limit_q     <= EXPIRY_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      chk_q       <= chk_d;
      next_id_q   <= next_id_d;
      next_slot_q <= next_slot_d;
      pend_q      <= pend_d;
      limit_q     <= limit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    rid_q        <= rid_d;
    quo_q        <= quo_d;
    now_q        <= now_d;
    addr_q       <= addr_d;
    chk_addr_q   <= chk_addr_d;
    exp_q        <= exp_d;
    res_id_q     <= res_id_d;
    res_rtt_q    <= res_rtt_d;
    res_found_q  <= res_found_d;
    res_status_q <= res_status_d;
    out_q        <= out_d;
  end

  `RRT_ASSERT(a_pend_bound, pend_q <= DEPTH_C, "pending count exceeds table depth")
  `RRT_ASSERT(a_slot_range, (state_q == S_LOOK) |-> (addr_q <= LAST), "slot index out of range")
  `RRT_ASSERT_NEXT(a_busy_hold, issue_busy, $stable(next_id_q), "refused issue moved next id")
  `RRT_ASSERT_NEXT(a_done_out, done_fire, out_valid_q && state_q == S_IDLE, "word not presented")

endmodule

FILE: tb/round_trip_request_tracker_tb.sv
`timescale 1ns / 100ps

module round_trip_request_tracker_tb;
  import rrt_pkg::*;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned STALL_LIMIT = 4000;  // cycles with no word moving on any channel
  localparam int unsigned HOLD_CYCLES = 400;   // long output hold-off for the pressure test
  localparam int unsigned PRINT_CAP   = 30;
  localparam int unsigned PHASE_WORDS = 190;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_LIGHT,
    RX_PATTERN,
    RX_HEAVY
  } rx_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  rrt_chan_if #(.T(in_word_t))    in_ch ();
  rrt_chan_if #(.T(out_word_t))   out_ch ();
  rrt_chan_if #(.T(logic [31:0])) cfg_ch ();

  round_trip_request_tracker #(.TABLE_DEPTH(DEPTH)) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  always #2 clk_i = ~clk_i;

  // Shadow of the request table, kept in step with every accepted input word.
  logic        slot_busy [DEPTH] = '{default: 1'b0};
  logic [31:0] slot_stamp [DEPTH];
  logic [31:0] slot_ident [DEPTH];
  logic [31:0] ident_counter = '0;
  int unsigned outstanding   = 0;
  logic [31:0] expiry_shadow = EXPIRY_RESET;

  // Results owed by the block, oldest first.
  out_word_t   owed_results[$];
  out_word_t   want_w;

  // Stimulus state.
  logic [31:0] clock_us = '0;
  int unsigned burst_left = 0;
  bit          sender_steady = 1'b0;

  // Receiver state.
  int unsigned hold_left = 0;
  int unsigned rx_cycle  = 0;
  rx_mode_e    rx_mode   = RX_OPEN;

  // Bookkeeping.
  int unsigned err_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned words_sent = 0;
  int unsigned op_seen [4] = '{default: 0};
  int unsigned refused_cnt = 0;
  int unsigned matched_cnt = 0;
  int unsigned freed_cnt   = 0;
  int unsigned cfg_writes  = 0;

  task automatic flag_error(input string msg);
    if (err_count < PRINT_CAP) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
    err_count++;
  endtask

  // Work out the one result that an input word causes and advance the shadow table.
  function automatic out_word_t tracker_outcome(input in_word_t w);
    out_word_t   r;
    int unsigned s;
    logic [31:0] age;
    r = '0;
    case (w.op)
      OP_ISSUE: begin
        s = ident_counter % DEPTH;
        if (slot_busy[s]) begin
          // slot still taken: refuse, leave the counter where it is
          r.status = STATUS_BUSY;
          refused_cnt++;
        end else begin
          slot_busy[s]  = 1'b1;
          slot_stamp[s] = w.now_time;
          slot_ident[s] = ident_counter;
          r.new_id      = ident_counter;
          ident_counter = ident_counter + 32'd1;
          outstanding++;
        end
      end
      OP_REPLY: begin
        s = w.reply_id % DEPTH;
        if (slot_busy[s] && slot_ident[s] == w.reply_id) begin
          r.round_trip = w.now_time - slot_stamp[s];  // wraps mod 2^32
          r.found      = 1'b1;
          slot_busy[s] = 1'b0;
          if (outstanding > 0) outstanding--;
          matched_cnt++;
        end
      end
      OP_SWEEP: begin
        for (int i = 0; i < DEPTH; i++) begin
          age = w.now_time - slot_stamp[i];
          if (slot_busy[i] && age > expiry_shadow) begin
            slot_busy[i] = 1'b0;
            r.expired_count = r.expired_count + 5'd1;
            if (outstanding > 0) outstanding--;
            freed_cnt++;
          end
        end
      end
      default: ;
    endcase
    r.pending_count = 5'(outstanding);
    return r;
  endfunction

  function automatic in_word_t make_word(input op_e op, input logic [31:0] rid,
                                         input logic [31:0] now);
    in_word_t w;
    w.op       = op;
    w.reply_id = rid;
    w.now_time = now;
    return w;
  endfunction

  // Offer one word and hold it until taken. Valid stays high after the handshake so that
  // a burst runs back to back; within this task it drops only in the gap between bursts.
  task automatic send_word(input in_word_t w);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
      if (sender_steady) gap = 0;
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk_i); while (!in_ch.ready);
    owed_results.push_back(tracker_outcome(w));
    op_seen[w.op]++;
    words_sent++;
  endtask

  // Drop valid and hold until every owed result has come back.
  task automatic wait_for_drain();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (owed_results.size() != 0) @(posedge clk_i);
  endtask

  // Write the expiry limit only with the block idle.
  task automatic write_expiry(input logic [31:0] limit);
    wait_for_drain();
    repeat (8) @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= limit;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    expiry_shadow = limit;
    cfg_writes++;
  endtask

  // Mostly well-formed traffic: replies carry a pending identifier most of the time, the
  // rest aim at the right slot with the wrong identifier, at stale identifiers, or anywhere.
  task automatic random_word(output in_word_t w);
    int unsigned pick;
    int unsigned live[$];
    w.reply_id = $urandom();
    if ($urandom_range(0, 19) == 0) clock_us += $urandom();
    else clock_us += $urandom_range(0, 60);
    w.now_time = ($urandom_range(0, 11) == 0) ? $urandom() : clock_us;
    pick = $urandom_range(0, 99);
    if (pick < 38) begin
      w.op = OP_ISSUE;
    end else if (pick < 78) begin
      w.op = OP_REPLY;
      foreach (slot_busy[i]) begin
        if (slot_busy[i]) live.push_back(i);
      end
      pick = $urandom_range(0, 9);
      if (live.size() != 0 && pick < 8) begin
        w.reply_id = slot_ident[live[$urandom_range(0, live.size() - 1)]];
        // flip a bit above the slot index: same slot, other identifier
        if (pick >= 6) w.reply_id ^= 32'h1 << $urandom_range(4, 31);
      end else if (pick < 9) begin
        w.reply_id = ident_counter - $urandom_range(1, 40);
      end
    end else if (pick < 90) begin
      w.op = OP_SWEEP;
    end else begin
      w.op = OP_QUERY;
    end
  endtask

  task automatic test_empty_table();
    send_word(make_word(OP_QUERY, 32'h0, 32'h0));
    send_word(make_word(OP_REPLY, 32'h0, 32'h0));
    send_word(make_word(OP_SWEEP, 32'hffff_ffff, 32'hffff_ffff));
  endtask

  // Fill every slot with stamps that straddle the time wrap, then ask for one more.
  task automatic test_fill_and_busy();
    for (int k = 0; k < DEPTH; k++) begin
      send_word(make_word(OP_ISSUE, 32'hffff_ffff ^ k, 32'hffff_fff8 + k));
    end
    send_word(make_word(OP_ISSUE, 32'h0, 32'h10));
  endtask

  task automatic test_reply_matching();
    send_word(make_word(OP_REPLY, 32'd3, 32'd2));           // elapsed time wraps
    send_word(make_word(OP_REPLY, 32'd3, 32'd9));           // already freed
    send_word(make_word(OP_REPLY, 32'h8000_0004, 32'd9));   // slot busy, other identifier
    send_word(make_word(OP_REPLY, 32'd0, 32'h7fff_ffff));
    send_word(make_word(OP_ISSUE, 32'd0, 32'h8000_0000));   // takes the freed slot
  endtask

  task automatic test_expiry_extremes();
    write_expiry(32'hffff_ffff);
    send_word(make_word(OP_SWEEP, 32'd0, 32'h7fff_fff0));   // nothing can be older
    write_expiry(32'd0);
    send_word(make_word(OP_SWEEP, 32'd0, 32'hffff_fffa));   // all but the same-stamp entry
    send_word(make_word(OP_QUERY, 32'hffff_ffff, 32'd0));
  endtask

  // Hold the output off for a long stretch while words keep coming, so the block fills
  // and stalls its input; then pause the sender until every result is back.
  task automatic test_backpressure();
    sender_steady = 1'b1;
    hold_left = HOLD_CYCLES;
    in_ch.valid <= 1'b0;
    burst_left = 0;
    repeat (2) @(posedge clk_i);
    for (int k = 0; k < 12; k++) begin
      clock_us += 32'd7;
      send_word(make_word((k % 2 == 0) ? OP_ISSUE : OP_QUERY, $urandom(), clock_us));
    end
    wait_for_drain();
    sender_steady = 1'b0;
  endtask

  task automatic test_random_traffic();
    logic [31:0] limits [8];
    in_word_t    w;
    limits = '{32'd1, 32'd500, 32'd5000, 32'h7fff_ffff, 32'd0, 32'hffff_ffff, 32'd0,
               EXPIRY_RESET};
    limits[6] = $urandom();
    for (int p = 0; p < 8; p++) begin
      write_expiry(limits[p]);
      sender_steady = (p == 2);
      repeat (PHASE_WORDS) begin
        random_word(w);
        send_word(w);
      end
    end
    sender_steady = 1'b0;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      flag_error($sformatf("%s got %h want %h", name, got, want));
    end
  endtask

  // Compare every result taken from the block with the oldest owed one.
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (owed_results.size() == 0) begin
        flag_error($sformatf("result %h with nothing owed", out_ch.data));
      end else begin
        want_w = owed_results.pop_front();
        check_field("new_id", out_ch.data.new_id, want_w.new_id);
        check_field("round_trip", out_ch.data.round_trip, want_w.round_trip);
        check_field("found", 32'(out_ch.data.found), 32'(want_w.found));
        check_field("expired_count", 32'(out_ch.data.expired_count),
                    32'(want_w.expired_count));
        check_field("pending_count", 32'(out_ch.data.pending_count),
                    32'(want_w.pending_count));
        check_field("status", 32'(out_ch.data.status), 32'(want_w.status));
      end
    end
  end

  // Receiver: stall on a randomly chosen pattern that changes over the run, including open
  // stretches; a requested hold-off overrides it.
  initial begin
    out_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      rx_cycle++;
      if (rx_cycle % 300 == 0) rx_mode = rx_mode_e'($urandom_range(0, 3));
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN:    out_ch.ready <= 1'b1;
          RX_LIGHT:   out_ch.ready <= ($urandom_range(0, 3) != 0);
          RX_PATTERN: out_ch.ready <= ((rx_cycle % 7) >= 3);
          default:    out_ch.ready <= ($urandom_range(0, 9) < 3);
        endcase
      end
    end
  end

  // Watchdog: end the run if no word moves on any channel for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
          || (cfg_ch.valid && cfg_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
        $display("status: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    rst_ni       <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data  <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_empty_table();
    test_fill_and_busy();
    test_reply_matching();
    test_expiry_extremes();
    test_backpressure();
    test_random_traffic();

    // Let the last results come back, then allow for the slowest operation.
    wait_for_drain();
    repeat (60) @(posedge clk_i);
    while (owed_results.size() != 0) begin
      want_w = owed_results.pop_front();
      flag_error($sformatf("result %h never came", want_w));
    end

    $display("covered %0d words: %0d issue (%0d refused), %0d reply (%0d matched),",
             words_sent, op_seen[OP_ISSUE], refused_cnt, op_seen[OP_REPLY], matched_cnt);
    $display("  %0d sweep (%0d freed), %0d query; %0d limit writes; %0d mismatches",
             op_seen[OP_SWEEP], freed_cnt, op_seen[OP_QUERY], cfg_writes, err_count);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
